// ===== rtl/mhpq_pkg.sv =====
`default_nettype none

package mhpq_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic OPC_INSERT = 1'b0;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/min_heap_priority_queue.sv =====
`default_nettype none

// Binary min-heap in a synchronous two-read, one-write store; root kept in a register.
// A full, empty, first-key or last-key request goes straight to the done state. An insert
// sifts the key up through S_UP_CMP (and S_UP_FIN at the root); a delete fetches the last
// key in S_DN_LAST and sifts it down through S_DN_CMP. Throughput: one request at a time,
// taken once its predecessor's result is registered. Reset: count, state and output
// valid cleared at once; the store is not cleared. A result waits in the output register.
module min_heap_priority_queue #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           opcode,
    input  wire logic signed [mhpq_pkg::DATA_W-1:0] key_in,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [mhpq_pkg::DATA_W-1:0]  removed_key,
    output logic [mhpq_pkg::STATUS_W-1:0]       status,
    output logic signed [mhpq_pkg::DATA_W-1:0]  min_key,
    output logic                                min_valid,
    output logic [mhpq_pkg::COUNT_W-1:0]        element_count
);
    import mhpq_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = ADDR_W + 2;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_CMP  = 3'd1;
    localparam logic [2:0] S_UP_FIN  = 3'd2;
    localparam logic [2:0] S_DN_LAST = 3'd3;
    localparam logic [2:0] S_DN_CMP  = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [KEY_WIDTH-1:0] heap_mem [CAPACITY];

    logic [2:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [ADDR_W-1:0]           pos_reg, pos_next;
    logic signed [KEY_WIDTH-1:0] key_reg, key_next;
    logic signed [KEY_WIDTH-1:0] root_reg, root_next;
    logic signed [KEY_WIDTH-1:0] res_removed_reg, res_removed_next;
    logic [STATUS_W-1:0]         res_status_reg, res_status_next;
    logic signed [KEY_WIDTH-1:0] rd0_reg, rd1_reg;
    logic                        out_valid_reg;
    logic signed [DATA_W-1:0]    out_removed_reg, out_min_reg;
    logic [STATUS_W-1:0]         out_status_reg;
    logic                        out_min_valid_reg;
    logic [COUNT_W-1:0]          out_count_reg;

    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_wa, ra0, ra1;
    logic [KEY_WIDTH-1:0]        mem_wd;
    logic                        accept, out_free;
    logic signed [KEY_WIDTH-1:0] key_cvt;
    logic [ADDR_W-1:0]           up_idx, up_up_idx, cnt_parent, best_addr;
    logic [IDX_W-1:0]            l_idx, r_idx, best_idx, best_l;
    logic                        l_ok, r_ok, moved;
    logic signed [KEY_WIDTH-1:0] best_val;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign key_cvt   = KEY_WIDTH'(key_in);

    assign up_idx     = ADDR_W'((pos_reg - 1'b1) >> 1);
    assign up_up_idx  = ADDR_W'((up_idx - 1'b1) >> 1);
    assign cnt_parent = ADDR_W'((cnt_reg - 1'b1) >> 1);

    // Children of the current node and the smallest of node, left, right
    assign l_idx = {1'b0, pos_reg, 1'b1};
    assign r_idx = l_idx + 1'b1;
    assign l_ok  = l_idx < IDX_W'(cnt_reg);
    assign r_ok  = r_idx < IDX_W'(cnt_reg);

    always_comb
    begin
        best_val = key_reg;
        best_idx = IDX_W'(pos_reg);
        moved    = 1'b0;
        if (l_ok && (rd0_reg < best_val))
        begin
            best_val = rd0_reg;
            best_idx = l_idx;
            moved    = 1'b1;
        end
        if (r_ok && (rd1_reg < best_val))
        begin
            best_val = rd1_reg;
            best_idx = r_idx;
            moved    = 1'b1;
        end
    end

    assign best_addr = ADDR_W'(best_idx);
    assign best_l    = {1'b0, best_addr, 1'b1};

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        pos_next         = pos_reg;
        key_next         = key_reg;
        root_next        = root_reg;
        res_removed_next = res_removed_reg;
        res_status_next  = res_status_reg;
        mem_we           = 1'b0;
        mem_wa           = pos_reg;
        mem_wd           = key_reg;
        ra0              = '0;
        ra1              = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_removed_next = '0;
                    res_status_next  = ST_OK;
                    state_next       = S_DONE;
                    if (opcode == OPC_INSERT)
                    begin
                        if (cnt_reg == CNT_W'(CAPACITY))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else if (cnt_reg == '0)
                        begin
                            mem_we    = 1'b1;
                            mem_wa    = '0;
                            mem_wd    = key_cvt;
                            root_next = key_cvt;
                            cnt_next  = CNT_W'(1);
                        end
                        else
                        begin
                            pos_next   = ADDR_W'(cnt_reg);
                            key_next   = key_cvt;
                            cnt_next   = cnt_reg + 1'b1;
                            ra0        = cnt_parent;
                            state_next = S_UP_CMP;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            res_removed_next = root_reg;
                            cnt_next         = cnt_reg - 1'b1;
                            if (cnt_reg != CNT_W'(1))
                            begin
                                // fetch the last key, it becomes the new root
                                ra0        = ADDR_W'(cnt_reg - 1'b1);
                                pos_next   = '0;
                                state_next = S_DN_LAST;
                            end
                        end
                    end
                end
            end
            S_UP_CMP:
            begin
                mem_we = 1'b1;
                mem_wa = pos_reg;
                if (key_reg < rd0_reg)
                begin
                    mem_wd   = rd0_reg;
                    pos_next = up_idx;
                    ra0      = up_up_idx;
                    if (up_idx == '0)
                        state_next = S_UP_FIN;
                end
                else
                begin
                    mem_wd     = key_reg;
                    state_next = S_DONE;
                end
            end
            S_UP_FIN:
            begin
                mem_we     = 1'b1;
                mem_wa     = '0;
                mem_wd     = key_reg;
                root_next  = key_reg;
                state_next = S_DONE;
            end
            S_DN_LAST:
            begin
                key_next   = rd0_reg;
                ra0        = ADDR_W'(1);
                ra1        = ADDR_W'(2);
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                mem_we = 1'b1;
                mem_wa = pos_reg;
                mem_wd = best_val;
                if (pos_reg == '0)
                    root_next = best_val;
                if (moved)
                begin
                    pos_next = best_addr;
                    ra0      = ADDR_W'(best_l);
                    ra1      = ADDR_W'(best_l + 1'b1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            heap_mem[mem_wa] <= mem_wd;
        rd0_reg <= heap_mem[ra0];
        rd1_reg <= heap_mem[ra1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if ((state_reg == S_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        key_reg         <= key_next;
        root_reg        <= root_next;
        res_removed_reg <= res_removed_next;
        res_status_reg  <= res_status_next;
        if ((state_reg == S_DONE) && out_free)
        begin
            out_removed_reg   <= DATA_W'(res_removed_reg);
            out_status_reg    <= res_status_reg;
            out_min_reg       <= (cnt_reg != '0) ? DATA_W'(root_reg) : '0;
            out_min_valid_reg <= (cnt_reg != '0);
            out_count_reg     <= COUNT_W'(cnt_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed_key   = out_removed_reg;
    assign status        = out_status_reg;
    assign min_key       = out_min_reg;
    assign min_valid     = out_min_valid_reg;
    assign element_count = out_count_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("element count beyond capacity");

    a_dn_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DN_CMP) |-> (IDX_W'(pos_reg) < IDX_W'(cnt_reg)))
        else $error("sift-down position outside the heap");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_FULL)) |->
            (out_count_reg == COUNT_W'(CAPACITY)))
        else $error("full status with heap not full");

    a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_EMPTY)) |->
            (!out_min_valid_reg && (out_removed_reg == '0)))
        else $error("empty status with a key reported");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OPC_INSERT) && (cnt_reg != CNT_W'(CAPACITY))) |=>
            (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("insert did not grow the heap");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mhpq_pkg::*;

    localparam int   HEAP_DEPTH = 64;
    localparam logic OPC_DELETE = ~OPC_INSERT;
    localparam int   HOLD_CYCLES = 300;

    typedef struct packed {
        logic signed [DATA_W-1:0]  removed;
        logic [STATUS_W-1:0]       st;
        logic signed [DATA_W-1:0]  minimum;
        logic                      min_ok;
        logic [COUNT_W-1:0]        count;
    } heap_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic                        opcode = OPC_INSERT;
    logic signed [DATA_W-1:0]    key_in = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [DATA_W-1:0]    removed_key;
    logic [STATUS_W-1:0]         status;
    logic signed [DATA_W-1:0]    min_key;
    logic                        min_valid;
    logic [COUNT_W-1:0]          element_count;

    // predictor state
    logic signed [DATA_W-1:0]    heap_keys [HEAP_DEPTH];
    int unsigned                 heap_fill = 0;
    heap_result_t                pending_results [$];

    int  errors = 0;
    bit  steady = 1'b0;       // no random idling on either side while set
    bit  hold_request = 1'b0; // asks the checker to start a receiver hold-off
    int  hold_left = 0;

    min_heap_priority_queue #(
        .CAPACITY (HEAP_DEPTH),
        .KEY_WIDTH(DATA_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .key_in       (key_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .removed_key  (removed_key),
        .status       (status),
        .min_key      (min_key),
        .min_valid    (min_valid),
        .element_count(element_count)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void heap_sift_down();
        int unsigned pos;
        int unsigned l;
        int unsigned r;
        int unsigned best;
        bit          done;
        logic signed [DATA_W-1:0] t;
        pos  = 0;
        done = 1'b0;
        while (!done)
        begin
            l    = 2 * pos + 1;
            r    = 2 * pos + 2;
            best = pos;
            if (l < heap_fill && heap_keys[l] < heap_keys[best]) best = l;
            if (r < heap_fill && heap_keys[r] < heap_keys[best]) best = r;
            if (best == pos)
                done = 1'b1;
            else
            begin
                t               = heap_keys[pos];
                heap_keys[pos]  = heap_keys[best];
                heap_keys[best] = t;
                pos             = best;
            end
        end
    endfunction

    // Applies one request to the predictor and returns the result it should give.
    function automatic heap_result_t apply_request(logic op, logic signed [DATA_W-1:0] key);
        heap_result_t res;
        int unsigned  pos;
        res         = '0;
        res.st      = ST_OK;
        if (op == OPC_INSERT)
        begin
            if (heap_fill >= HEAP_DEPTH)
                res.st = ST_FULL;
            else
            begin
                pos = heap_fill;
                while (pos > 0 && key < heap_keys[(pos - 1) / 2])
                begin
                    heap_keys[pos] = heap_keys[(pos - 1) / 2];
                    pos = (pos - 1) / 2;
                end
                heap_keys[pos] = key;
                heap_fill++;
            end
        end
        else
        begin
            if (heap_fill == 0)
                res.st = ST_EMPTY;
            else
            begin
                res.removed  = heap_keys[0];
                heap_fill--;
                heap_keys[0] = heap_keys[heap_fill];
                heap_sift_down();
            end
        end
        res.min_ok  = (heap_fill > 0);
        res.minimum = (heap_fill > 0) ? heap_keys[0] : '0;
        res.count   = COUNT_W'(heap_fill);
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 25)
            return DATA_W'(int'($urandom_range(16)) - 8);   // dense range for ties
        if (sel < 35)
        begin
            case ($urandom_range(3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return '0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_request(input logic op, input logic signed [DATA_W-1:0] key);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 34) gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        key_in   <= key;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_results.push_back(apply_request(op, key));
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic empty_heap();
        while (heap_fill != 0) send_request(OPC_DELETE, pick_key());
    endtask

    // result checker and receiver-side stalls
    initial
    begin
        heap_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: removed_key %0d status %0d", removed_key, status);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (removed_key !== want.removed)
                    begin
                        $error("removed_key: expected %0d, got %0d", want.removed, removed_key);
                        errors++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        errors++;
                    end
                    if (min_key !== want.minimum)
                    begin
                        $error("min_key: expected %0d, got %0d", want.minimum, min_key);
                        errors++;
                    end
                    if (min_valid !== want.min_ok)
                    begin
                        $error("min_valid: expected %0d, got %0d", want.min_ok, min_valid);
                        errors++;
                    end
                    if (element_count !== want.count)
                    begin
                        $error("element_count: expected %0d, got %0d", want.count, element_count);
                        errors++;
                    end
                end
            end
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) hold_left--;
            out_stall <= (hold_left > 0) || (!steady && $urandom_range(99) < 34);
        end
    end

    task automatic test_empty_and_extremes();
        send_request(OPC_DELETE, 32'sh7fff_ffff);
        send_request(OPC_DELETE, 32'sh8000_0000);
        send_request(OPC_INSERT, 32'sh7fff_ffff);
        send_request(OPC_INSERT, 32'sh8000_0000);
        send_request(OPC_INSERT, '0);
        send_request(OPC_INSERT, -32'sd1);
        send_request(OPC_INSERT, 32'sd1);
        send_request(OPC_INSERT, 32'sh7fff_ffff);
        send_request(OPC_INSERT, 32'sh8000_0000);
        repeat (8) send_request(OPC_DELETE, '0);
        wait_all_results();
    endtask

    // fill to capacity, push a few more, then drain past empty
    task automatic test_full_heap();
        empty_heap();
        repeat (HEAP_DEPTH) send_request(OPC_INSERT, pick_key());
        repeat (3) send_request(OPC_INSERT, pick_key());
        repeat (HEAP_DEPTH + 1) send_request(OPC_DELETE, pick_key());
        wait_all_results();
    endtask

    // heap-sort rounds: n keys in, n + 1 out
    task automatic test_sort_rounds();
        int n;
        empty_heap();
        repeat (20)
        begin
            n = $urandom_range(1, 40);
            repeat (n) send_request(OPC_INSERT, pick_key());
            repeat (n + 1) send_request(OPC_DELETE, pick_key());
        end
        wait_all_results();
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_back_pressure();
        steady       = 1'b1;
        hold_request = 1'b1;
        repeat (40) send_request(OPC_INSERT, pick_key());
        steady = 1'b0;
        wait_all_results();
    endtask

    task automatic test_random_mix();
        bit ins;
        for (int i = 0; i < 900; i++)
        begin
            steady = (i >= 300 && i < 500);
            if (heap_fill < 8)
                ins = ($urandom_range(99) < 70);
            else if (heap_fill > 56)
                ins = ($urandom_range(99) < 30);
            else
                ins = 1'($urandom_range(1));
            send_request(ins ? OPC_INSERT : OPC_DELETE, pick_key());
        end
        steady = 1'b0;
        wait_all_results();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_extremes();
        test_full_heap();
        test_sort_rounds();
        test_back_pressure();
        test_random_mix();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== min_heap_priority_queue.f =====
rtl/mhpq_pkg.sv
rtl/min_heap_priority_queue.sv
tb/testbench.sv
